[rtl/core/slc_pkg.sv]
// Shared types and constants for the scalar literal classifier.
// Holds the item and result types and the pseudo literal spelling table.
// No dependencies.
package slc_pkg;

	typedef enum logic [2:0] {
		KIND_INVALID = 3'd0,
		KIND_CHAR    = 3'd1,
		KIND_INT     = 3'd2,
		KIND_FLOAT   = 3'd3,
		KIND_DOUBLE  = 3'd4,
		KIND_PSEUDO  = 3'd5
	} slc_kind_t;

	localparam int NUM_KEYWORDS = 8;
	localparam int POS_W = 3;

	localparam logic [7:0] CH_QUOTE = 8'h27;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LOW_F = 8'h66;
	localparam logic [7:0] CH_UP_F  = 8'h46;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TILDE = 8'h7E;

	// One byte of the token as it travels through the input register.
	typedef struct packed {
		logic [7:0] char_code;
		logic       is_last;
		logic       is_empty;
	} slc_item_t;

	// What the lexer reports for the byte held in the input register.
	typedef struct packed {
		logic      emit;
		slc_kind_t kind;
	} slc_result_t;

	// Spelling of each pseudo literal: nan nanf +inf -inf inf +inff -inff inff.
	function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [POS_W-1:0] pos);
		logic [7:0] c;
		c = 8'h00;
		case (k)
			3'd0: case (pos) 3'd0: c = "n"; 3'd1: c = "a"; 3'd2: c = "n"; default: c = 8'h00; endcase
			3'd1: case (pos) 3'd0: c = "n"; 3'd1: c = "a"; 3'd2: c = "n"; 3'd3: c = "f";
				default: c = 8'h00; endcase
			3'd2: case (pos) 3'd0: c = "+"; 3'd1: c = "i"; 3'd2: c = "n"; 3'd3: c = "f";
				default: c = 8'h00; endcase
			3'd3: case (pos) 3'd0: c = "-"; 3'd1: c = "i"; 3'd2: c = "n"; 3'd3: c = "f";
				default: c = 8'h00; endcase
			3'd4: case (pos) 3'd0: c = "i"; 3'd1: c = "n"; 3'd2: c = "f"; default: c = 8'h00; endcase
			3'd5: case (pos) 3'd0: c = "+"; 3'd1: c = "i"; 3'd2: c = "n"; 3'd3: c = "f";
				3'd4: c = "f"; default: c = 8'h00; endcase
			3'd6: case (pos) 3'd0: c = "-"; 3'd1: c = "i"; 3'd2: c = "n"; 3'd3: c = "f";
				3'd4: c = "f"; default: c = 8'h00; endcase
			3'd7: case (pos) 3'd0: c = "i"; 3'd1: c = "n"; 3'd2: c = "f"; 3'd3: c = "f";
				default: c = 8'h00; endcase
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [POS_W-1:0] kw_len(input logic [2:0] k);
		logic [POS_W-1:0] n;
		case (k)
			3'd0: n = 3'd3;
			3'd1: n = 3'd4;
			3'd2: n = 3'd4;
			3'd3: n = 3'd4;
			3'd4: n = 3'd3;
			3'd5: n = 3'd5;
			3'd6: n = 3'd5;
			3'd7: n = 3'd4;
			default: n = 3'd0;
		endcase
		return n;
	endfunction

endpackage

[rtl/core/slc_if.sv]
// Channel interfaces of the scalar literal classifier: byte items in, kinds out.
// Depends on slc_pkg for the kind type.
interface slc_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       is_last;
	logic       is_empty;

	modport source (output valid, output char_code, output is_last, output is_empty,
		input ready);
	modport sink (input valid, input char_code, input is_last, input is_empty,
		output ready);
endinterface

interface slc_kind_if;
	logic                valid;
	logic                ready;
	slc_pkg::slc_kind_t  literal_kind;

	modport source (output valid, output literal_kind, input ready);
	modport sink (input valid, input literal_kind, output ready);
endinterface

[rtl/core/slc_in_stage.sv]
// Input register of the scalar literal classifier.
// Captures one byte item per cycle and holds it until the lexer consumes it.
// Depends on slc_pkg and slc_char_if.
module slc_in_stage (
	input  logic                clk,
	input  logic                arst_n,
	slc_char_if.sink            chars,
	input  logic                adv,
	output logic                valid_s1,
	output slc_pkg::slc_item_t  item_s1
);

	logic take;

	// The register is free when empty or when its item leaves this cycle.
	assign chars.ready = !valid_s1 || adv;
	assign take = chars.valid && chars.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.char_code <= chars.char_code;
			item_s1.is_last   <= chars.is_last;
			item_s1.is_empty  <= chars.is_empty;
		end
	end

endmodule

[rtl/core/slc_lexer.sv]
// Token flag automaton of the scalar literal classifier.
// Updates the per-token flags with each consumed byte and classifies on the last one.
// Depends on slc_pkg.
module slc_lexer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  slc_pkg::slc_item_t   item_s1,
	input  logic                 adv,
	output slc_pkg::slc_result_t res
);

	logic [slc_pkg::POS_W-1:0]        char_position_q;
	logic                             quote_form_ok_q;
	logic                             int_form_ok_q;
	logic                             digit_seen_q;
	logic                             decimal_form_ok_q;
	logic                             dot_seen_q;
	logic [slc_pkg::NUM_KEYWORDS-1:0] keyword_alive_q;

	logic [slc_pkg::POS_W-1:0]        pos_nxt;
	logic                             quote_nxt;
	logic                             int_nxt;
	logic                             digit_nxt;
	logic                             decimal_nxt;
	logic                             dot_nxt;
	logic [slc_pkg::NUM_KEYWORDS-1:0] alive_nxt;
	logic                             pseudo_hit;
	logic [7:0]                       c;
	logic                             is_digit;
	logic                             is_dot;
	logic                             is_sign;
	logic                             is_f;
	logic                             printable;
	logic                             pos0;

	assign c         = item_s1.char_code;
	assign is_digit  = (c >= slc_pkg::CH_ZERO) && (c <= slc_pkg::CH_NINE);
	assign is_dot    = (c == slc_pkg::CH_DOT);
	assign is_sign   = (c == slc_pkg::CH_PLUS) || (c == slc_pkg::CH_MINUS);
	assign is_f      = (c == slc_pkg::CH_LOW_F) || (c == slc_pkg::CH_UP_F);
	assign printable = (c >= slc_pkg::CH_SPACE) && (c <= slc_pkg::CH_TILDE);
	assign pos0      = (char_position_q == '0);

	always_comb begin
		case (char_position_q)
			3'd0: quote_nxt = quote_form_ok_q && (c == slc_pkg::CH_QUOTE);
			3'd1: quote_nxt = quote_form_ok_q && printable;
			3'd2: quote_nxt = quote_form_ok_q && (c == slc_pkg::CH_QUOTE);
			default: quote_nxt = 1'b0;
		endcase
		int_nxt     = int_form_ok_q && (is_digit || (pos0 && is_sign));
		decimal_nxt = decimal_form_ok_q &&
			(is_digit || (is_dot && !dot_seen_q) || (pos0 && is_sign));
		digit_nxt   = digit_seen_q || is_digit;
		dot_nxt     = dot_seen_q || is_dot;
		pos_nxt     = (char_position_q == '1) ? char_position_q : char_position_q + 1'b1;
		pseudo_hit  = 1'b0;
		for (int k = 0; k < slc_pkg::NUM_KEYWORDS; k++) begin
			alive_nxt[k] = keyword_alive_q[k] &&
				(char_position_q < slc_pkg::kw_len(3'(k))) &&
				(slc_pkg::kw_char(3'(k), char_position_q) == c);
			if (alive_nxt[k] && (char_position_q + 1'b1 == slc_pkg::kw_len(3'(k))))
				pseudo_hit = 1'b1;
		end
	end

	always_comb begin
		res.emit = item_s1.is_last || item_s1.is_empty;
		if (item_s1.is_empty) begin
			res.kind = slc_pkg::KIND_INVALID;
		end else if (quote_nxt && (char_position_q == 3'd2)) begin
			res.kind = slc_pkg::KIND_CHAR;
		end else if (int_nxt && digit_nxt) begin
			res.kind = slc_pkg::KIND_INT;
		end else if (is_f && decimal_form_ok_q && dot_seen_q && digit_seen_q) begin
			// The float form is judged on the flags before the suffix byte.
			res.kind = slc_pkg::KIND_FLOAT;
		end else if (decimal_nxt && dot_nxt && digit_nxt) begin
			res.kind = slc_pkg::KIND_DOUBLE;
		end else if (pseudo_hit) begin
			res.kind = slc_pkg::KIND_PSEUDO;
		end else begin
			res.kind = slc_pkg::KIND_INVALID;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_position_q   <= '0;
			quote_form_ok_q   <= 1'b1;
			int_form_ok_q     <= 1'b1;
			digit_seen_q      <= 1'b0;
			decimal_form_ok_q <= 1'b1;
			dot_seen_q        <= 1'b0;
			keyword_alive_q   <= '1;
		end else if (adv) begin
			if (res.emit) begin
				char_position_q   <= '0;
				quote_form_ok_q   <= 1'b1;
				int_form_ok_q     <= 1'b1;
				digit_seen_q      <= 1'b0;
				decimal_form_ok_q <= 1'b1;
				dot_seen_q        <= 1'b0;
				keyword_alive_q   <= '1;
			end else begin
				char_position_q   <= pos_nxt;
				quote_form_ok_q   <= quote_nxt;
				int_form_ok_q     <= int_nxt;
				digit_seen_q      <= digit_nxt;
				decimal_form_ok_q <= decimal_nxt;
				dot_seen_q        <= dot_nxt;
				keyword_alive_q   <= alive_nxt;
			end
		end
	end

`ifndef ASSERT_OFF
	// A finished token leaves the automaton in its start state.
	a_clear_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		adv && res.emit |=> char_position_q == '0 && keyword_alive_q == '1 && !dot_seen_q)
		else $error("token state not cleared after a result");

	// The quoted form cannot survive past its closing quote.
	a_quote_short: assert property (@(posedge clk) disable iff (!arst_n)
		quote_form_ok_q |-> char_position_q <= 3'd3)
		else $error("quoted form alive beyond three bytes");

	// An integer prefix of two or more bytes has a digit where every keyword has a letter.
	a_int_excludes_kw: assert property (@(posedge clk) disable iff (!arst_n)
		int_form_ok_q && char_position_q >= 3'd2 |-> keyword_alive_q == '0)
		else $error("keyword still alive in an integer token");

	// Unless the token ends, consuming a byte moves the position or holds it at saturation.
	a_pos_moves: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !res.emit |=> char_position_q != '0)
		else $error("position did not advance");
`endif

endmodule

[rtl/core/scalar_literal_classifier.sv]
// Scalar literal classifier: takes one byte of a literal token per item and
// returns one kind for each token when its last byte (or an empty marker)
// arrives. It accepts one byte every clock cycle. A last byte is held in the
// input register while the flags are updated, and its kind is then written
// to the result register, which presents it until it is taken. Only a result
// that is not taken holds back the input.
// Depends on slc_pkg, slc_if, slc_in_stage, slc_lexer.
module scalar_literal_classifier (
	input  logic        clk,
	input  logic        arst_n,
	slc_char_if.sink    chars,
	slc_kind_if.source  kinds
);

	logic                 valid_s1;
	slc_pkg::slc_item_t   item_s1;
	slc_pkg::slc_result_t res;
	logic                 adv;
	logic                 out_free;
	logic                 out_valid_q;
	slc_pkg::slc_kind_t   out_kind_q;

	// Bytes that end no token never need the result register.
	assign out_free = !out_valid_q || kinds.ready;
	assign adv      = valid_s1 && (!res.emit || out_free);

	slc_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.chars    (chars),
		.adv      (adv),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	slc_lexer u_lexer (
		.clk     (clk),
		.arst_n  (arst_n),
		.item_s1 (item_s1),
		.adv     (adv),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && res.emit) begin
			out_valid_q <= 1'b1;
		end else if (kinds.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res.emit) begin
			out_kind_q <= res.kind;
		end
	end

	assign kinds.valid        = out_valid_q;
	assign kinds.literal_kind = out_kind_q;

endmodule
